@@ rtl/icy_metadata_demux_core_defines.svh @@
// Assertion macros shared by the ICY metadata demux RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef ICY_METADATA_DEMUX_CORE_DEFINES_SVH
`define ICY_METADATA_DEMUX_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define ICYMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define ICYMD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ICYMD_ASSERT(lbl, prop, msg)
`define ICYMD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/icymd_pkg.sv @@
// Constants and widths for the ICY metadata demux.
// No dependencies; used by the channel interfaces and the core.
package icymd_pkg;

    // payload widths
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int META_W  = 12;

    // audio chunk grouping
    localparam int CHUNK_BYTES = 1024;
    localparam int CHUNK_W     = (CHUNK_BYTES > 2) ? $clog2(CHUNK_BYTES) : 1;
    localparam logic [CHUNK_W-1:0] CHUNK_LAST_FILL = CHUNK_W'(CHUNK_BYTES - 1);

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_META_INTERVAL = 1'b0;
    localparam logic REG_START_OFFSET  = 1'b1;

    // reset values of the registers
    localparam logic [COUNT_W-1:0] META_INTERVAL_RST = 16'd8192;
    localparam logic [COUNT_W-1:0] START_OFFSET_RST  = 16'd0;

endpackage

@@ rtl/icymd_in_if.sv @@
// Input byte channel of the ICY metadata demux.
// Depends on icymd_pkg for the byte width.
interface icymd_in_if;

    logic                          valid;
    logic                          ready;
    logic [icymd_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);

endinterface

@@ rtl/icymd_out_if.sv @@
// Result channel of the ICY metadata demux: tagged audio or metadata byte.
// Depends on icymd_pkg for the byte width.
interface icymd_out_if;

    logic                          valid;
    logic                          ready;
    logic [icymd_pkg::BYTE_W-1:0]  out_byte;
    logic                          is_metadata;
    logic                          chunk_last;
    logic                          meta_last;

    modport source (output valid, output out_byte, output is_metadata,
                    output chunk_last, output meta_last, input ready);
    modport sink   (input valid, input out_byte, input is_metadata,
                    input chunk_last, input meta_last, output ready);

endinterface

@@ rtl/icy_metadata_demux_core.sv @@
// ICY metadata demux core: splits an ICY byte stream into tagged audio and metadata bytes.
// Depends on icymd_pkg, icymd_in_if, icymd_out_if and icy_metadata_demux_core_defines.svh.
//
// channel   dir   protocol        payload
// stream    in    valid/ready     data_byte[7:0]
// result    out   valid/ready     out_byte[7:0], is_metadata, chunk_last, meta_last
// apb       in    APB write/read  meta_interval @0x0, start_offset @0x4
//
// One byte per clock unless the result channel stalls: each request is decoded against the stream
// counters in the cycle it is taken and its result lands in the output register in the next cycle.
// The output register is the only storage; stream.ready is low only while it holds
// an untaken result and result.ready is low. A length byte gives no result.
// Reset is asynchronous, active low, and needs no clearing pass.
`include "icy_metadata_demux_core_defines.svh"

module icy_metadata_demux_core (
    input  logic                                clk,
    input  logic                                rst_n,
    icymd_in_if.sink                            stream,
    icymd_out_if.source                         result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [icymd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [icymd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [icymd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam logic PH_AUDIO = 1'b0;
    localparam logic PH_META  = 1'b1;

    // configuration and stream state
    logic [icymd_pkg::COUNT_W-1:0] meta_interval_reg, meta_interval_next;
    logic [icymd_pkg::COUNT_W-1:0] start_offset_reg, start_offset_next;
    logic                          phase_reg, phase_next;
    logic [icymd_pkg::COUNT_W-1:0] audio_count_reg, audio_count_next;
    logic [icymd_pkg::META_W-1:0]  meta_total_reg, meta_total_next;
    logic [icymd_pkg::META_W-1:0]  meta_count_reg, meta_count_next;
    logic [icymd_pkg::CHUNK_W-1:0] chunk_fill_reg, chunk_fill_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [icymd_pkg::BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic                          is_metadata_reg, is_metadata_next;
    logic                          chunk_last_reg, chunk_last_next;
    logic                          meta_last_reg, meta_last_next;

    logic                          in_take;
    logic                          out_take;
    logic                          cfg_write;
    logic                          cfg_sel;
    logic [icymd_pkg::META_W-1:0]  meta_count_inc;
    logic                          meta_done;
    logic                          chunk_full;
    logic                          len_byte;

    // handshakes
    assign out_take  = out_valid_reg && result.ready;
    assign stream.ready = !out_valid_reg || result.ready;
    assign in_take   = stream.valid && stream.ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = paddr[2];

    // register read back
    always_comb
    begin
        unique case (cfg_sel)
            icymd_pkg::REG_META_INTERVAL:
                prdata = icymd_pkg::APB_DATA_W'(meta_interval_reg);
            icymd_pkg::REG_START_OFFSET:
                prdata = icymd_pkg::APB_DATA_W'(start_offset_reg);
            default:
                prdata = '0;
        endcase
    end

    // byte decode
    assign meta_count_inc = meta_count_reg + 1'b1;
    assign meta_done      = (meta_count_inc >= meta_total_reg);
    assign chunk_full     = (chunk_fill_reg == icymd_pkg::CHUNK_LAST_FILL);
    assign len_byte       = (audio_count_reg >= meta_interval_reg);

    // next state and result
    always_comb
    begin
        meta_interval_next = meta_interval_reg;
        start_offset_next  = start_offset_reg;
        phase_next         = phase_reg;
        audio_count_next   = audio_count_reg;
        meta_total_next    = meta_total_reg;
        meta_count_next    = meta_count_reg;
        chunk_fill_next    = chunk_fill_reg;
        out_valid_next     = out_valid_reg && !out_take;
        out_byte_next      = out_byte_reg;
        is_metadata_next   = is_metadata_reg;
        chunk_last_next    = chunk_last_reg;
        meta_last_next     = meta_last_reg;

        // configuration writes must arrive only while the stream is idle; the block itself does not enforce it
        if (cfg_write)
        begin
            unique case (cfg_sel)
                icymd_pkg::REG_META_INTERVAL:
                    meta_interval_next = pwdata[icymd_pkg::COUNT_W-1:0];
                icymd_pkg::REG_START_OFFSET:
                begin
                    start_offset_next = pwdata[icymd_pkg::COUNT_W-1:0];
                    audio_count_next  = pwdata[icymd_pkg::COUNT_W-1:0];
                end
                default:
                    ;
            endcase
        end

        if (in_take)
        begin
            priority if (phase_reg == PH_META)
            begin
                meta_count_next  = meta_count_inc;
                if (meta_done)
                    phase_next = PH_AUDIO;
                out_valid_next   = 1'b1;
                out_byte_next    = stream.data_byte;
                is_metadata_next = 1'b1;
                chunk_last_next  = 1'b0;
                meta_last_next   = meta_done;
            end
            else if (len_byte)
            begin
                // length byte: block length is sixteen times its value
                audio_count_next = '0;
                meta_total_next  = {stream.data_byte, 4'b0000};
                meta_count_next  = '0;
                phase_next       = (stream.data_byte != '0) ? PH_META : PH_AUDIO;
            end
            else
            begin
                audio_count_next = audio_count_reg + 1'b1;
                chunk_fill_next  = chunk_full ? '0 : chunk_fill_reg + 1'b1;
                out_valid_next   = 1'b1;
                out_byte_next    = stream.data_byte;
                is_metadata_next = 1'b0;
                chunk_last_next  = chunk_full;
                meta_last_next   = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_interval_reg <= icymd_pkg::META_INTERVAL_RST;
            start_offset_reg  <= icymd_pkg::START_OFFSET_RST;
            phase_reg         <= PH_AUDIO;
            audio_count_reg   <= icymd_pkg::START_OFFSET_RST;
            meta_total_reg    <= '0;
            meta_count_reg    <= '0;
            chunk_fill_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            meta_interval_reg <= meta_interval_next;
            start_offset_reg  <= start_offset_next;
            phase_reg         <= phase_next;
            audio_count_reg   <= audio_count_next;
            meta_total_reg    <= meta_total_next;
            meta_count_reg    <= meta_count_next;
            chunk_fill_reg    <= chunk_fill_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_byte_reg    <= out_byte_next;
        is_metadata_reg <= is_metadata_next;
        chunk_last_reg  <= chunk_last_next;
        meta_last_reg   <= meta_last_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.is_metadata = is_metadata_reg;
    assign result.chunk_last  = chunk_last_reg;
    assign result.meta_last   = meta_last_reg;

    // checks
    `ICYMD_ASSERT(a_meta_phase_nonempty,
        (phase_reg == PH_META) |-> (meta_total_reg != '0),
        "metadata phase entered with a zero-length block")
    `ICYMD_ASSERT(a_meta_count_below_total,
        (phase_reg == PH_META) |-> (meta_count_reg < meta_total_reg),
        "metadata count reached block length without leaving metadata phase")
    `ICYMD_ASSERT(a_meta_last_tag,
        (out_valid_reg && meta_last_reg) |-> is_metadata_reg,
        "block end flagged on an audio byte")
    `ICYMD_ASSERT(a_chunk_last_tag,
        (out_valid_reg && chunk_last_reg) |-> !is_metadata_reg,
        "chunk end flagged on a metadata byte")

endmodule

@@ tb/tb_icy_metadata_demux_core.sv @@
// Self-checking testbench for icy_metadata_demux_core: a predictor tracks the ICY framing
// counters and checks every tagged audio or metadata byte that the block hands back.
// Depends on icymd_pkg, icymd_in_if, icymd_out_if and the core RTL.
`timescale 1ns / 1ps

module tb_icy_metadata_demux_core;

    typedef enum logic [1:0] {
        PH_AUDIO = 2'd0,
        PH_META  = 2'd1
    } stream_phase_t;

    typedef struct packed {
        logic [icymd_pkg::BYTE_W-1:0] out_byte;
        logic                         is_metadata;
        logic                         chunk_last;
        logic                         meta_last;
    } tagged_byte_t;

    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 20000;

    logic clk;
    logic rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [icymd_pkg::APB_ADDR_W-1:0] paddr;
    logic [icymd_pkg::APB_DATA_W-1:0] pwdata;
    logic [icymd_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    icymd_in_if  stream_if ();
    icymd_out_if result_if ();

    icy_metadata_demux_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // pending stream bytes and tagged bytes still owed by the block
    logic [icymd_pkg::BYTE_W-1:0] stream_q[$];
    tagged_byte_t                 tagged_q[$];
    int                           err_count;
    int                           src_idle_pct;
    int                           dst_idle_pct;

    // framing state as the block should hold it
    logic [icymd_pkg::COUNT_W-1:0] cfg_interval;
    stream_phase_t                 pr_phase;
    logic [icymd_pkg::COUNT_W-1:0] pr_audio_count;
    logic [icymd_pkg::META_W-1:0]  pr_meta_total;
    logic [icymd_pkg::META_W-1:0]  pr_meta_count;
    int                            pr_chunk_fill;

    task report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        err_count++;
    endtask

    // work out what one accepted stream byte turns into
    function void demux_byte(input logic [icymd_pkg::BYTE_W-1:0] b);
        tagged_byte_t r;
        r          = '0;
        r.out_byte = b;
        if (pr_phase == PH_META)
        begin
            pr_meta_count = pr_meta_count + 1'b1;
            r.is_metadata = 1'b1;
            r.meta_last   = (pr_meta_count >= pr_meta_total);
            if (r.meta_last)
                pr_phase = PH_AUDIO;
            tagged_q.push_back(r);
        end
        else if (pr_audio_count >= cfg_interval)
        begin
            // length byte: no output, block length is sixteen times its value
            pr_audio_count = '0;
            pr_meta_total  = {b, 4'b0000};
            pr_meta_count  = '0;
            pr_phase       = (pr_meta_total != '0) ? PH_META : PH_AUDIO;
        end
        else
        begin
            pr_audio_count = pr_audio_count + 1'b1;
            pr_chunk_fill++;
            r.chunk_last = (pr_chunk_fill >= icymd_pkg::CHUNK_BYTES);
            if (r.chunk_last)
                pr_chunk_fill = 0;
            tagged_q.push_back(r);
        end
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // stream driver: takes bytes from the pending queue
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stream_if.valid <= 1'b0;
        end
        else
        begin
            if (stream_if.valid && stream_if.ready)
                demux_byte(stream_if.data_byte);
            if (!stream_if.valid || stream_if.ready)
            begin
                if (stream_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    stream_if.valid     <= 1'b1;
                    stream_if.data_byte <= stream_q.pop_front();
                end
                else
                begin
                    stream_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin : result_monitor
        tagged_byte_t want;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (tagged_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result byte %02h",
                                              result_if.out_byte));
                end
                else
                begin
                    want = tagged_q.pop_front();
                    if (result_if.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte got %02h expected %02h",
                                                  result_if.out_byte, want.out_byte));
                    if (result_if.is_metadata !== want.is_metadata)
                        report_mismatch($sformatf("is_metadata got %b expected %b",
                                                  result_if.is_metadata, want.is_metadata));
                    if (result_if.chunk_last !== want.chunk_last)
                        report_mismatch($sformatf("chunk_last got %b expected %b",
                                                  result_if.chunk_last, want.chunk_last));
                    if (result_if.meta_last !== want.meta_last)
                        report_mismatch($sformatf("meta_last got %b expected %b",
                                                  result_if.meta_last, want.meta_last));
                end
            end
            result_if.ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // register write over apb, then read it back
    task write_reg(input logic idx, input logic [icymd_pkg::COUNT_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= icymd_pkg::APB_DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == icymd_pkg::REG_META_INTERVAL)
        begin
            cfg_interval = val;
        end
        else
        begin
            pr_audio_count = val;
        end
        @(posedge clk);
        psel    <= 1'b1;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[icymd_pkg::COUNT_W-1:0] !== val)
            report_mismatch($sformatf("register %0d read %04h expected %04h",
                                      idx, prdata[icymd_pkg::COUNT_W-1:0], val));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until every request is taken and every result has come back
    task wait_idle();
        while (stream_q.size() != 0 || stream_if.valid || tagged_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // well-formed random stream picked up from the current framing position
    task automatic queue_stream(input int n, input bit big_block);
        int                            meta_left;
        int                            pick;
        logic [icymd_pkg::COUNT_W-1:0] cnt;
        logic [icymd_pkg::BYTE_W-1:0]  b;
        cnt       = pr_audio_count;
        meta_left = (pr_phase == PH_META) ? int'(pr_meta_total) - int'(pr_meta_count) : 0;
        for (int i = 0; i < n; i++)
        begin
            if (meta_left > 0)
            begin
                b = 8'($urandom_range(255));
                meta_left--;
            end
            else if (cnt >= cfg_interval)
            begin
                // length byte, mostly short blocks
                pick = int'($urandom_range(99));
                if (big_block)
                    b = 8'hFF;
                else if (pick < 35)
                    b = 8'h00;
                else if (pick < 85)
                    b = 8'($urandom_range(3, 1));
                else if (pick < 97)
                    b = 8'($urandom_range(8, 4));
                else
                    b = 8'($urandom_range(40, 9));
                big_block = 1'b0;
                meta_left = int'(b) * 16;
                cnt       = '0;
            end
            else
            begin
                b   = 8'($urandom_range(255));
                cnt = cnt + 1'b1;
            end
            stream_q.push_back(b);
        end
    endtask

    // run limit
    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    // main sequence
    initial
    begin
        int guard;
        rst_n               = 1'b0;
        stream_if.valid     = 1'b0;
        stream_if.data_byte = '0;
        result_if.ready     = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        err_count           = 0;
        src_idle_pct        = 13;
        dst_idle_pct        = 66;
        cfg_interval        = icymd_pkg::META_INTERVAL_RST;
        pr_phase            = PH_AUDIO;
        pr_audio_count      = icymd_pkg::START_OFFSET_RST;
        pr_meta_total       = '0;
        pr_meta_count       = '0;
        pr_chunk_fill       = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // audio under the reset settings
        stream_q = '{8'h00, 8'hFF, 8'h55, 8'hAA};
        wait_idle();

        // start offset written after reset, then a zero-length block
        write_reg(icymd_pkg::REG_START_OFFSET, 16'd8190);
        stream_q = '{8'h01, 8'h80, 8'h00, 8'h7E};
        wait_idle();

        // interval cut to one above the running count, one sixteen-byte block
        write_reg(icymd_pkg::REG_META_INTERVAL, 16'd2);
        stream_q = '{8'h33, 8'h01};
        for (int i = 0; i < 16; i++)
            stream_q.push_back(8'(i * 17));
        stream_q.push_back(8'hC3);
        wait_idle();

        // sender lightly idle, receiver mostly stalled
        write_reg(icymd_pkg::REG_META_INTERVAL, 16'd64);
        write_reg(icymd_pkg::REG_START_OFFSET, 16'd10);
        queue_stream(700, 1'b0);
        wait_idle();

        // roles swapped, interval of one, with a full pause halfway
        src_idle_pct = 66;
        dst_idle_pct = 13;
        write_reg(icymd_pkg::REG_META_INTERVAL, 16'd1);
        write_reg(icymd_pkg::REG_START_OFFSET, 16'd0);
        queue_stream(250, 1'b0);
        wait_idle();
        queue_stream(250, 1'b0);
        wait_idle();

        // zero interval: every audio-phase byte is a length byte
        write_reg(icymd_pkg::REG_META_INTERVAL, 16'd0);
        queue_stream(20, 1'b0);
        wait_idle();

        // top of range: offset at the interval, then one short of it
        write_reg(icymd_pkg::REG_META_INTERVAL, 16'hFFFF);
        write_reg(icymd_pkg::REG_START_OFFSET, 16'hFFFF);
        queue_stream(30, 1'b0);
        wait_idle();
        write_reg(icymd_pkg::REG_START_OFFSET, 16'hFFFE);
        queue_stream(30, 1'b0);
        wait_idle();

        // no idling, a long audio run
        src_idle_pct = 0;
        dst_idle_pct = 0;
        write_reg(icymd_pkg::REG_META_INTERVAL, 16'd1000);
        write_reg(icymd_pkg::REG_START_OFFSET, 16'd400);
        queue_stream(640, 1'b0);

        // drain and finish
        while (stream_q.size() != 0 || stream_if.valid)
            @(posedge clk);
        guard = 0;
        while (tagged_q.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (tagged_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", tagged_q.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
